[rtl/lpg_pkg.sv]
package lpg_pkg;

    // Defaults for the top-level parameters
    localparam int NUM_LEDS_DEF  = 3;
    localparam int TIME_BITS_DEF = 24;

    // Fixed field widths
    localparam int FUNC_W     = 4;
    localparam int IDX_W      = 2;
    localparam int PERIOD_W   = 24;
    localparam int BLINKS_W   = 7;
    localparam int CHANGES_W  = 8;
    localparam int OUT_W      = 3;
    localparam int CFG_W      = 3;
    localparam int TIME_W_MAX = 32;

    // Register port
    localparam int APB_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;
    localparam int REG_ADDR_LSB  = 2;
    localparam int REG_IDX_W     = APB_ADDR_W - REG_ADDR_LSB;
    localparam logic [REG_IDX_W-1:0] REG_ACTIVE_HIGH_MASK = '0;

    // Command codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK     = 4'd0,
        FUNC_SET      = 4'd1,
        FUNC_CLEAR    = 4'd2,
        FUNC_TOGGLE   = 4'd3,
        FUNC_STATUS   = 4'd4,
        FUNC_BLINK    = 4'd5,
        FUNC_BLINK_SOME = 4'd6,
        FUNC_BURST    = 4'd7,
        FUNC_ONE_SHOT = 4'd8
    } func_t;

    // Per-LED mode, one-hot
    typedef enum logic [4:0] {
        MODE_STATIC = 5'b00001,
        MODE_BLINK  = 5'b00010,
        MODE_SOME   = 5'b00100,
        MODE_BURST  = 5'b01000,
        MODE_SHOT   = 5'b10000
    } mode_t;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [IDX_W-1:0]    led_index;
        logic                want_on;
        logic [PERIOD_W-1:0] period;
        logic [PERIOD_W-1:0] fast_period;
        logic [BLINKS_W-1:0] blinks;
    } in_item_t;

    typedef struct packed {
        logic [OUT_W-1:0] pin_levels;
        logic [OUT_W-1:0] busy_mask;
    } out_item_t;

endpackage

[rtl/lpg_apb_regs.sv]
module lpg_apb_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lpg_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [lpg_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [lpg_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output logic [lpg_pkg::CFG_W-1:0]       active_high_mask
);

    logic [lpg_pkg::CFG_W-1:0]     mask_reg;
    logic [lpg_pkg::REG_IDX_W-1:0] reg_idx;
    logic                          wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[lpg_pkg::APB_ADDR_W-1:lpg_pkg::REG_ADDR_LSB];
    assign wr_en   = psel && penable && pwrite && pready;

    // Register write on the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
        end else if (wr_en && (reg_idx == lpg_pkg::REG_ACTIVE_HIGH_MASK)) begin
            mask_reg <= pwdata[lpg_pkg::CFG_W-1:0];
        end
    end

    // Read mux
    always_comb begin
        prdata = '0;
        if (reg_idx == lpg_pkg::REG_ACTIVE_HIGH_MASK) begin
            prdata[lpg_pkg::CFG_W-1:0] = mask_reg;
        end
    end

    assign active_high_mask = mask_reg;

endmodule

[rtl/lpg_led_unit.sv]
module lpg_led_unit #(
    parameter int TIME_BITS = lpg_pkg::TIME_BITS_DEF,
    parameter int LED_ID    = 0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  lpg_pkg::in_item_t item,
    input  logic              act_level,
    output logic              pin_next,
    output logic              busy_next
);

    localparam int MAXW = lpg_pkg::TIME_W_MAX;
    localparam int PW   = lpg_pkg::PERIOD_W;
    localparam int CW   = lpg_pkg::CHANGES_W;
    localparam int BW   = lpg_pkg::BLINKS_W;
    localparam logic [TIME_BITS-1:0] ONE  = {{(TIME_BITS-1){1'b0}}, 1'b1};
    localparam logic [CW-1:0]        ONE8 = {{(CW-1){1'b0}}, 1'b1};
    localparam bit ADDRESSABLE = (LED_ID < (1 << lpg_pkg::IDX_W));
    localparam logic [lpg_pkg::IDX_W-1:0] LED_CODE = LED_ID[lpg_pkg::IDX_W-1:0];

    lpg_pkg::mode_t       mode_reg, mode_next;
    logic                 pin_reg;
    logic [TIME_BITS-1:0] saved_period_reg, saved_period_next;
    logic [TIME_BITS-1:0] tick_cnt_reg, tick_cnt_next;
    logic [TIME_BITS-1:0] burst_period_reg, burst_period_next;
    logic [TIME_BITS-1:0] burst_cnt_reg, burst_cnt_next;
    logic [BW-1:0]        blinks_reg, blinks_next;
    logic [CW-1:0]        changes_reg, changes_next;

    logic [MAXW-1:0]      per_wide, fast_wide;
    logic [TIME_BITS-1:0] per_t, fast_t;
    logic [TIME_BITS-1:0] tick_dec, burst_dec;
    logic [CW-1:0]        changes_dec, toggles_cmd, toggles_saved;
    logic                 addressed, is_tick, is_cmd;

    function automatic logic [TIME_BITS-1:0] at_least_one(input logic [TIME_BITS-1:0] v);
        at_least_one = (v == '0) ? ONE : v;
    endfunction

    function automatic logic [TIME_BITS-1:0] half_of(input logic [TIME_BITS-1:0] p);
        half_of = at_least_one(p >> 1);
    endfunction

    // 2*blinks-1, wraps to all ones for zero blinks
    function automatic logic [CW-1:0] toggles_for(input logic [BW-1:0] b);
        toggles_for = {b, 1'b0} - ONE8;
    endfunction

    // Times in TIME_BITS, truncated or zero-extended
    assign per_wide  = {{(MAXW-PW){1'b0}}, item.period};
    assign fast_wide = {{(MAXW-PW){1'b0}}, item.fast_period};
    assign per_t     = per_wide[TIME_BITS-1:0];
    assign fast_t    = fast_wide[TIME_BITS-1:0];

    assign tick_dec      = tick_cnt_reg - ONE;
    assign burst_dec     = burst_cnt_reg - ONE;
    assign changes_dec   = changes_reg - ONE8;
    assign toggles_cmd   = toggles_for(item.blinks);
    assign toggles_saved = toggles_for(blinks_reg);

    assign addressed = ADDRESSABLE && (item.led_index == LED_CODE);
    assign is_tick   = step && (item.func == lpg_pkg::FUNC_TICK);
    assign is_cmd    = step && addressed && (item.func >= lpg_pkg::FUNC_SET)
                       && (item.func <= lpg_pkg::FUNC_ONE_SHOT);

    // Next state: tick advance or command load
    always_comb begin
        mode_next         = mode_reg;
        pin_next          = pin_reg;
        saved_period_next = saved_period_reg;
        tick_cnt_next     = tick_cnt_reg;
        burst_period_next = burst_period_reg;
        burst_cnt_next    = burst_cnt_reg;
        blinks_next       = blinks_reg;
        changes_next      = changes_reg;

        if (is_tick) begin
            unique case (mode_reg)
                lpg_pkg::MODE_BLINK: begin
                    tick_cnt_next = tick_dec;
                    if (tick_dec == '0) begin
                        pin_next      = ~pin_reg;
                        tick_cnt_next = half_of(saved_period_reg);
                    end
                end
                lpg_pkg::MODE_SOME: begin
                    tick_cnt_next = tick_dec;
                    if (tick_dec == '0) begin
                        pin_next     = ~pin_reg;
                        changes_next = changes_dec;
                        if (changes_dec == '0) begin
                            mode_next = lpg_pkg::MODE_STATIC;
                        end else begin
                            tick_cnt_next = half_of(saved_period_reg);
                        end
                    end
                end
                lpg_pkg::MODE_BURST: begin
                    burst_cnt_next = burst_dec;
                    if (burst_dec == '0) begin
                        // start of a new burst
                        pin_next       = act_level;
                        burst_cnt_next = at_least_one(burst_period_reg);
                        tick_cnt_next  = half_of(saved_period_reg);
                        changes_next   = toggles_saved;
                    end else if (changes_reg != '0) begin
                        tick_cnt_next = tick_dec;
                        if (tick_dec == '0) begin
                            pin_next      = ~pin_reg;
                            tick_cnt_next = half_of(saved_period_reg);
                            changes_next  = changes_dec;
                        end
                    end
                end
                lpg_pkg::MODE_SHOT: begin
                    tick_cnt_next = tick_dec;
                    if (tick_dec == '0) begin
                        pin_next  = ~act_level;
                        mode_next = lpg_pkg::MODE_STATIC;
                    end
                end
                default: begin
                end
            endcase
        end else if (is_cmd) begin
            unique case (item.func)
                lpg_pkg::FUNC_SET: begin
                    pin_next  = act_level;
                    mode_next = lpg_pkg::MODE_STATIC;
                end
                lpg_pkg::FUNC_CLEAR: begin
                    pin_next  = ~act_level;
                    mode_next = lpg_pkg::MODE_STATIC;
                end
                lpg_pkg::FUNC_TOGGLE: begin
                    pin_next  = ~pin_reg;
                    mode_next = lpg_pkg::MODE_STATIC;
                end
                lpg_pkg::FUNC_STATUS: begin
                    pin_next  = item.want_on ? act_level : ~act_level;
                    mode_next = lpg_pkg::MODE_STATIC;
                end
                lpg_pkg::FUNC_BLINK: begin
                    saved_period_next = per_t;
                    tick_cnt_next     = half_of(per_t);
                    pin_next          = act_level;
                    mode_next         = lpg_pkg::MODE_BLINK;
                end
                lpg_pkg::FUNC_BLINK_SOME: begin
                    saved_period_next = per_t;
                    tick_cnt_next     = half_of(per_t);
                    changes_next      = toggles_cmd;
                    pin_next          = act_level;
                    mode_next         = lpg_pkg::MODE_SOME;
                end
                lpg_pkg::FUNC_BURST: begin
                    burst_period_next = per_t;
                    saved_period_next = fast_t;
                    burst_cnt_next    = at_least_one(per_t);
                    tick_cnt_next     = half_of(fast_t);
                    blinks_next       = item.blinks;
                    changes_next      = toggles_cmd;
                    pin_next          = act_level;
                    mode_next         = lpg_pkg::MODE_BURST;
                end
                lpg_pkg::FUNC_ONE_SHOT: begin
                    tick_cnt_next = at_least_one(per_t);
                    pin_next      = act_level;
                    mode_next     = lpg_pkg::MODE_SHOT;
                end
                default: begin
                end
            endcase
        end
    end

    assign busy_next = (mode_next != lpg_pkg::MODE_STATIC);

    // State registers; pin resets to the inactive level of an all-low mask
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= lpg_pkg::MODE_STATIC;
            pin_reg          <= 1'b1;
            saved_period_reg <= '0;
            tick_cnt_reg     <= '0;
            burst_period_reg <= '0;
            burst_cnt_reg    <= '0;
            blinks_reg       <= '0;
            changes_reg      <= '0;
        end else begin
            mode_reg         <= mode_next;
            pin_reg          <= pin_next;
            saved_period_reg <= saved_period_next;
            tick_cnt_reg     <= tick_cnt_next;
            burst_period_reg <= burst_period_next;
            burst_cnt_reg    <= burst_cnt_next;
            blinks_reg       <= blinks_next;
            changes_reg      <= changes_next;
        end
    end

endmodule

[rtl/led_pattern_generator.sv]
// Channel   Ports                    Payload               Direction
// command   s_valid/s_ready/s_data   lpg_pkg::in_item_t    in
// status    m_valid/m_ready/m_data   lpg_pkg::out_item_t   out
// register  APB psel..pready         active_high_mask      in/out
//
// One command or tick per cycle while the result is not stalled. The input transfer
// loads the input register; the result register and m_valid load when the item advances.
// Every LED unit updates its counters in parallel in the cycle the item leaves
// the input register. Reset is synchronous, active low; no clearing pass.
// A stalled result holds the pipe; one further item waits in the input register.
module led_pattern_generator #(
    parameter int NUM_LEDS  = lpg_pkg::NUM_LEDS_DEF,
    parameter int TIME_BITS = lpg_pkg::TIME_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  lpg_pkg::in_item_t               s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output lpg_pkg::out_item_t              m_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lpg_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [lpg_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [lpg_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    localparam int OUT_W = lpg_pkg::OUT_W;
    localparam int CFG_W = lpg_pkg::CFG_W;

    logic                 in_valid_reg;
    lpg_pkg::in_item_t    in_item_reg;
    logic                 m_valid_reg;
    lpg_pkg::out_item_t   m_data_reg, m_data_next;
    logic                 advance;
    logic [CFG_W-1:0]     active_high_mask;
    logic [NUM_LEDS-1:0]  act_levels, pins_next, busy_next;

    // Configuration registers
    lpg_apb_regs u_regs (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .active_high_mask (active_high_mask)
    );

    // Pipe control: item moves on when the result register is free
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
    end

    // Per-LED units
    for (genvar g = 0; g < NUM_LEDS; g++) begin : g_led
        if (g < CFG_W) begin : g_act
            assign act_levels[g] = active_high_mask[g];
        end else begin : g_noact
            assign act_levels[g] = 1'b0;
        end

        lpg_led_unit #(
            .TIME_BITS (TIME_BITS),
            .LED_ID    (g)
        ) u_led (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .step      (advance),
            .item      (in_item_reg),
            .act_level (act_levels[g]),
            .pin_next  (pins_next[g]),
            .busy_next (busy_next[g])
        );
    end

    // Result bits; LEDs beyond the reported width are not shown
    for (genvar b = 0; b < OUT_W; b++) begin : g_out
        if (b < NUM_LEDS) begin : g_used
            assign m_data_next.pin_levels[b] = pins_next[b];
            assign m_data_next.busy_mask[b]  = busy_next[b];
        end else begin : g_unused
            assign m_data_next.pin_levels[b] = 1'b0;
            assign m_data_next.busy_mask[b]  = 1'b0;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Checks
    a_hold_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_item_reg))
        else $error("pending item lost or overwritten");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && m_valid_reg && !m_ready)
        else $error("input stalled without a blocked result");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid_reg)
        else $error("result missing after advance");

    a_capture: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> in_valid_reg)
        else $error("accepted item not held");

endmodule

[sim/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEDS        = lpg_pkg::NUM_LEDS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 185;
    localparam int SETTLE      = 6;

    // Field widths used here
    localparam int FUNC_W    = lpg_pkg::FUNC_W;
    localparam int IDX_W     = lpg_pkg::IDX_W;
    localparam int PERIOD_W  = lpg_pkg::PERIOD_W;
    localparam int BLINKS_W  = lpg_pkg::BLINKS_W;
    localparam int CHANGES_W = lpg_pkg::CHANGES_W;
    localparam int CFG_W     = lpg_pkg::CFG_W;
    localparam int ADDR_W    = lpg_pkg::APB_ADDR_W;
    localparam int DATA_W    = lpg_pkg::APB_DATA_W;
    localparam int ADDR_LSB  = lpg_pkg::REG_ADDR_LSB;

    // Codes past the last command do nothing
    localparam logic [FUNC_W-1:0] FUNC_UNUSED_LO = FUNC_W'(lpg_pkg::FUNC_ONE_SHOT + 1);
    localparam logic [FUNC_W-1:0] FUNC_UNUSED_HI = '1;
    localparam logic [PERIOD_W-1:0] TIME_MAX = '1;

    // Shadow copy of every LED unit and the status it should report
    class led_state_tracker;
        logic [CFG_W-1:0]     mask;
        lpg_pkg::mode_t       led_mode[LEDS];
        logic                 pin[LEDS];
        logic [PERIOD_W-1:0]  saved_per[LEDS];
        logic [PERIOD_W-1:0]  tick_cnt[LEDS];
        logic [PERIOD_W-1:0]  burst_per[LEDS];
        logic [PERIOD_W-1:0]  burst_cnt[LEDS];
        logic [BLINKS_W-1:0]  blinks_st[LEDS];
        logic [CHANGES_W-1:0] changes[LEDS];
        lpg_pkg::out_item_t   status_due[$];
        int                   errors;
        int                   checked;
        int                   commands;

        function new();
            mask = '0;
            errors = 0;
            checked = 0;
            commands = 0;
            for (int i = 0; i < LEDS; i++) begin
                led_mode[i]  = lpg_pkg::MODE_STATIC;
                pin[i]       = ~mask[i];
                saved_per[i] = '0;
                tick_cnt[i]  = '0;
                burst_per[i] = '0;
                burst_cnt[i] = '0;
                blinks_st[i] = '0;
                changes[i]   = '0;
            end
        endfunction

        // zero times are raised to one tick
        function logic [PERIOD_W-1:0] at_least_one(logic [PERIOD_W-1:0] v);
            return (v == '0) ? PERIOD_W'(1) : v;
        endfunction

        function logic [PERIOD_W-1:0] half_of(logic [PERIOD_W-1:0] p);
            return at_least_one(p >> 1);
        endfunction

        // 2*blinks-1 in 8 bits; zero blinks wraps to 255
        function logic [CHANGES_W-1:0] toggles_for(logic [BLINKS_W-1:0] b);
            logic [CHANGES_W-1:0] t;
            t = {b, 1'b0};
            return t - CHANGES_W'(1);
        endfunction

        // One tick for one LED
        function void advance(int i);
            case (led_mode[i])
                lpg_pkg::MODE_BLINK: begin
                    tick_cnt[i] = tick_cnt[i] - 1'b1;
                    if (tick_cnt[i] == '0) begin
                        pin[i] = ~pin[i];
                        tick_cnt[i] = half_of(saved_per[i]);
                    end
                end
                lpg_pkg::MODE_SOME: begin
                    tick_cnt[i] = tick_cnt[i] - 1'b1;
                    if (tick_cnt[i] == '0) begin
                        pin[i] = ~pin[i];
                        changes[i] = changes[i] - 1'b1;
                        if (changes[i] == '0)
                            led_mode[i] = lpg_pkg::MODE_STATIC;
                        else
                            tick_cnt[i] = half_of(saved_per[i]);
                    end
                end
                lpg_pkg::MODE_BURST: begin
                    burst_cnt[i] = burst_cnt[i] - 1'b1;
                    if (burst_cnt[i] == '0) begin
                        pin[i]       = mask[i];
                        burst_cnt[i] = at_least_one(burst_per[i]);
                        tick_cnt[i]  = half_of(saved_per[i]);
                        changes[i]   = toggles_for(blinks_st[i]);
                    end else if (changes[i] != '0) begin
                        tick_cnt[i] = tick_cnt[i] - 1'b1;
                        if (tick_cnt[i] == '0) begin
                            pin[i]      = ~pin[i];
                            tick_cnt[i] = half_of(saved_per[i]);
                            changes[i]  = changes[i] - 1'b1;
                        end
                    end
                end
                lpg_pkg::MODE_SHOT: begin
                    tick_cnt[i] = tick_cnt[i] - 1'b1;
                    if (tick_cnt[i] == '0) begin
                        pin[i]      = ~mask[i];
                        led_mode[i] = lpg_pkg::MODE_STATIC;
                    end
                end
                default: ;
            endcase
        endfunction

        // Apply one accepted command or tick and queue the status it gives
        function void take_command(lpg_pkg::in_item_t it);
            int                 idx;
            logic               act;
            lpg_pkg::out_item_t st;
            idx = it.led_index;
            commands++;
            if (it.func == lpg_pkg::FUNC_TICK) begin
                for (int i = 0; i < LEDS; i++)
                    advance(i);
            end else if (it.func <= lpg_pkg::FUNC_ONE_SHOT && idx < LEDS) begin
                act = mask[idx];
                case (it.func)
                    lpg_pkg::FUNC_SET: begin
                        pin[idx] = act;
                        led_mode[idx] = lpg_pkg::MODE_STATIC;
                    end
                    lpg_pkg::FUNC_CLEAR: begin
                        pin[idx] = ~act;
                        led_mode[idx] = lpg_pkg::MODE_STATIC;
                    end
                    lpg_pkg::FUNC_TOGGLE: begin
                        pin[idx] = ~pin[idx];
                        led_mode[idx] = lpg_pkg::MODE_STATIC;
                    end
                    lpg_pkg::FUNC_STATUS: begin
                        pin[idx] = it.want_on ? act : ~act;
                        led_mode[idx] = lpg_pkg::MODE_STATIC;
                    end
                    lpg_pkg::FUNC_BLINK: begin
                        saved_per[idx] = it.period;
                        tick_cnt[idx]  = half_of(it.period);
                        pin[idx]       = act;
                        led_mode[idx]  = lpg_pkg::MODE_BLINK;
                    end
                    lpg_pkg::FUNC_BLINK_SOME: begin
                        saved_per[idx] = it.period;
                        tick_cnt[idx]  = half_of(it.period);
                        changes[idx]   = toggles_for(it.blinks);
                        pin[idx]       = act;
                        led_mode[idx]  = lpg_pkg::MODE_SOME;
                    end
                    lpg_pkg::FUNC_BURST: begin
                        burst_per[idx] = it.period;
                        saved_per[idx] = it.fast_period;
                        burst_cnt[idx] = at_least_one(it.period);
                        tick_cnt[idx]  = half_of(it.fast_period);
                        blinks_st[idx] = it.blinks;
                        changes[idx]   = toggles_for(it.blinks);
                        pin[idx]       = act;
                        led_mode[idx]  = lpg_pkg::MODE_BURST;
                    end
                    default: begin
                        tick_cnt[idx] = at_least_one(it.period);
                        pin[idx]      = act;
                        led_mode[idx] = lpg_pkg::MODE_SHOT;
                    end
                endcase
            end
            st = '0;
            for (int i = 0; i < LEDS; i++) begin
                st.pin_levels[i] = pin[i];
                st.busy_mask[i]  = (led_mode[i] != lpg_pkg::MODE_STATIC);
            end
            status_due.push_back(st);
        endfunction

        // Compare a status transfer with the oldest one due
        function void check_status(lpg_pkg::out_item_t got);
            lpg_pkg::out_item_t want;
            if (status_due.size() == 0) begin
                $display("%0t ERROR: status pins=%b busy=%b arrived with none due",
                         $time, got.pin_levels, got.busy_mask);
                errors++;
                return;
            end
            want = status_due.pop_front();
            checked++;
            if (got.pin_levels !== want.pin_levels) begin
                $display("%0t ERROR: pin_levels expected %b actual %b",
                         $time, want.pin_levels, got.pin_levels);
                errors++;
            end
            if (got.busy_mask !== want.busy_mask) begin
                $display("%0t ERROR: busy_mask expected %b actual %b",
                         $time, want.busy_mask, got.busy_mask);
                errors++;
            end
        endfunction

        function int pending();
            return status_due.size();
        endfunction
    endclass

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    lpg_pkg::in_item_t     s_data  = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    lpg_pkg::out_item_t    m_data;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [ADDR_W-1:0]     paddr   = '0;
    logic [DATA_W-1:0]     pwdata  = '0;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;

    led_state_tracker leds = new();
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cycles         = 0;
    int mask_writes    = 0;

    led_pattern_generator DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t ERROR: run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("** led_pattern_generator: FAILED **");
            $finish;
        end
    end

    // Receiver back-pressure
    always @(posedge aclk)
        m_ready <= ($urandom_range(99) >= recv_stall_pct);

    // Watch both channels
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                leds.take_command(s_data);
            if (m_valid && m_ready)
                leds.check_status(m_data);
        end
    end

    function automatic lpg_pkg::in_item_t make_cmd(logic [FUNC_W-1:0] func, int idx,
                                                   bit want,
                                                   logic [PERIOD_W-1:0] per,
                                                   logic [PERIOD_W-1:0] fast,
                                                   logic [BLINKS_W-1:0] blk);
        lpg_pkg::in_item_t it;
        it.func        = func;
        it.led_index   = IDX_W'(idx);
        it.want_on     = want;
        it.period      = per;
        it.fast_period = fast;
        it.blinks      = blk;
        return it;
    endfunction

    // Mostly short times so that timed modes run their course
    function automatic logic [PERIOD_W-1:0] pick_time();
        int r;
        r = $urandom_range(99);
        if (r < 85)
            return PERIOD_W'($urandom_range(12));
        else if (r < 95)
            return PERIOD_W'($urandom_range(255));
        return PERIOD_W'($urandom());
    endfunction

    function automatic lpg_pkg::in_item_t pick_cmd();
        lpg_pkg::in_item_t it;
        int                r;
        r = $urandom_range(99);
        it.led_index   = ($urandom_range(15) == 0) ? IDX_W'(LEDS) :
                         IDX_W'($urandom_range(LEDS - 1));
        it.want_on     = $urandom_range(1);
        it.period      = pick_time();
        it.fast_period = pick_time();
        it.blinks      = ($urandom_range(4) != 0) ? BLINKS_W'($urandom_range(4)) :
                         BLINKS_W'($urandom_range(127));
        if (r < 68)
            it.func = lpg_pkg::FUNC_TICK;
        else if (r < 96)
            it.func = FUNC_W'($urandom_range(lpg_pkg::FUNC_ONE_SHOT, lpg_pkg::FUNC_SET));
        else
            it.func = FUNC_W'($urandom_range(FUNC_UNUSED_HI, FUNC_UNUSED_LO));
        return it;
    endfunction

    // One input transfer, with random idle cycles ahead of it
    task automatic send_item(input lpg_pkg::in_item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    // Hold the sender until every status due has been seen
    task automatic drain();
        s_valid <= 1'b0;
        while (leds.pending() != 0)
            @(negedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // APB write of the polarity register; block is idle here
    task automatic write_mask(input logic [CFG_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {lpg_pkg::REG_ACTIVE_HIGH_MASK, ADDR_LSB'(0)};
        pwdata  <= DATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        leds.mask = value;
        mask_writes++;
    endtask

    task automatic run_directed();
        // static commands, out-of-range LED and unused codes
        send_item(make_cmd(lpg_pkg::FUNC_STATUS, 0, 1, '0, '0, '0));
        send_item(make_cmd(lpg_pkg::FUNC_STATUS, 1, 0, '0, '0, '0));
        send_item(make_cmd(lpg_pkg::FUNC_SET, 2, 0, '0, '0, '0));
        send_item(make_cmd(lpg_pkg::FUNC_CLEAR, 2, 1, '0, '0, '0));
        send_item(make_cmd(lpg_pkg::FUNC_TOGGLE, 0, 0, '0, '0, '0));
        send_item(make_cmd(lpg_pkg::FUNC_SET, LEDS, 1, TIME_MAX, TIME_MAX, '1));
        send_item(make_cmd(FUNC_UNUSED_LO, 0, 0, '0, '0, '0));
        send_item(make_cmd(FUNC_UNUSED_HI, 1, 1, TIME_MAX, TIME_MAX, '1));
        // zero half period, zero blinks, zero burst and fast periods
        send_item(make_cmd(lpg_pkg::FUNC_BLINK, 0, 0, '0, '0, '0));
        send_item(make_cmd(lpg_pkg::FUNC_BLINK_SOME, 1, 0, PERIOD_W'(1), '0, '0));
        send_item(make_cmd(lpg_pkg::FUNC_BURST, 2, 0, '0, '0, BLINKS_W'(1)));
        repeat (4)
            send_item(make_cmd(lpg_pkg::FUNC_TICK, LEDS, 1, TIME_MAX, TIME_MAX, '1));
        // zero one-shot duration
        send_item(make_cmd(lpg_pkg::FUNC_ONE_SHOT, 1, 0, '0, '0, '0));
        repeat (2) send_item(make_cmd(lpg_pkg::FUNC_TICK, 0, 0, '0, '0, '0));
        // longest times and blink count
        send_item(make_cmd(lpg_pkg::FUNC_ONE_SHOT, 0, 1, TIME_MAX, '0, '0));
        send_item(make_cmd(lpg_pkg::FUNC_BURST, 2, 1, TIME_MAX, TIME_MAX, '1));
        send_item(make_cmd(lpg_pkg::FUNC_BLINK_SOME, 1, 1, PERIOD_W'(3), '0,
                           BLINKS_W'(1)));
        repeat (4) send_item(make_cmd(lpg_pkg::FUNC_TICK, 2, 0, '0, '0, '0));
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] mask, input int send_pct,
                             input int recv_pct);
        drain();
        write_mask(mask);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n == PHASE_ITEMS / 2)
                drain();
            send_item(pick_cmd());
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_mask('0);
        run_directed();

        run_phase('1, 0, 0);
        run_phase(CFG_W'(3'b010), 54, 0);
        run_phase('0, 0, 54);
        run_phase(CFG_W'($urandom_range(7)), 12, 12);
        run_phase(CFG_W'(3'b101), 0, 0);

        drain();
        recv_stall_pct = 0;
        repeat (SETTLE) @(posedge aclk);

        $display("Sent %0d commands and ticks, checked %0d status transfers,",
                 leds.commands, leds.checked);
        $display("under %0d polarity settings and four idle/stall mixes.", mask_writes);
        if (leds.errors == 0 && leds.pending() == 0) begin
            $display("** led_pattern_generator: PASSED **");
        end else begin
            $display("%0d mismatches, %0d status transfers outstanding",
                     leds.errors, leds.pending());
            $display("** led_pattern_generator: FAILED **");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/lpg_pkg.sv
rtl/lpg_apb_regs.sv
rtl/lpg_led_unit.sv
rtl/led_pattern_generator.sv
sim/tb.sv
